@@ src/wbs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the weighted two-dimensional bin sampler.
// Used by the register file, the controller, the datapath and the top level.
package wbs_pkg;

   localparam int ADDR_FIELD_W  = 12;
   localparam int WEIGHT_BITS   = 16;
   localparam int FRACTION_BITS = 16;
   localparam int DIM_W         = 7;
   localparam int IDX_W         = 6;
   localparam int CNT_W         = 13;
   localparam int COORD_W       = 32;
   localparam int BW_W          = 31;
   localparam int CP_W          = IDX_W + 1 + BW_W;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;
   localparam int GRID_MAX      = 64;
   localparam int GRID_CELLS    = GRID_MAX * GRID_MAX;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [2:0] REG_COLS   = 3'd0;
   localparam logic [2:0] REG_ROWS   = 3'd1;
   localparam logic [2:0] REG_X_ORG  = 3'd2;
   localparam logic [2:0] REG_Y_ORG  = 3'd3;
   localparam logic [2:0] REG_X_BW   = 3'd4;
   localparam logic [2:0] REG_Y_BW   = 3'd5;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_READ,
      ST_WR_COMMIT,
      ST_SMP_INIT,
      ST_WALK,
      ST_CTR_MUL,
      ST_CTR_SUM,
      ST_EMPTY
   } wbs_state_type;

   typedef struct packed {
      logic [DIM_W-1:0]          cols;
      logic [DIM_W-1:0]          rows;
      logic signed [COORD_W-1:0] x_origin;
      logic signed [COORD_W-1:0] y_origin;
      logic [BW_W-1:0]           x_bin_width;
      logic [BW_W-1:0]           y_bin_width;
   } wbs_cfg_type;

   typedef struct packed {
      logic clr_en;
      logic cap_req;
      logic wr_commit;
      logic smp_init;
      logic walk;
      logic ctr_mul;
      logic ctr_sum;
      logic out_empty;
   } wbs_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic wr_in_range;
      logic total_zero;
      logic hit;
      logic walk_end;
   } wbs_sts_type;

endpackage

@@ src/wbs_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on wbs_pkg for the register map and the configuration struct.
module wbs_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [wbs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [wbs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [wbs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output wbs_pkg::wbs_cfg_type               cfg
);
   import wbs_pkg::*;

   wbs_cfg_type cfg_ff;
   wbs_cfg_type cfg_in;
   logic [2:0]  reg_sel;
   logic        wr_en;

   assign reg_sel = paddr[4:2];
   assign wr_en   = psel && penable && pwrite && pready;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_COLS:  cfg_in.cols        = pwdata[DIM_W-1:0];
            REG_ROWS:  cfg_in.rows        = pwdata[DIM_W-1:0];
            REG_X_ORG: cfg_in.x_origin    = pwdata[COORD_W-1:0];
            REG_Y_ORG: cfg_in.y_origin    = pwdata[COORD_W-1:0];
            REG_X_BW:  cfg_in.x_bin_width = pwdata[BW_W-1:0];
            REG_Y_BW:  cfg_in.y_bin_width = pwdata[BW_W-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_COLS:  prdata = CSR_DATA_W'(cfg_ff.cols);
         REG_ROWS:  prdata = CSR_DATA_W'(cfg_ff.rows);
         REG_X_ORG: prdata = CSR_DATA_W'(unsigned'(cfg_ff.x_origin));
         REG_Y_ORG: prdata = CSR_DATA_W'(unsigned'(cfg_ff.y_origin));
         REG_X_BW:  prdata = CSR_DATA_W'(cfg_ff.x_bin_width);
         REG_Y_BW:  prdata = CSR_DATA_W'(cfg_ff.y_bin_width);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cols        <= DIM_W'(GRID_MAX);
         cfg_ff.rows        <= DIM_W'(GRID_MAX);
         cfg_ff.x_origin    <= '0;
         cfg_ff.y_origin    <= '0;
         cfg_ff.x_bin_width <= BW_W'(65536);
         cfg_ff.y_bin_width <= BW_W'(65536);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/wbs_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: sequences clearing, weight writes and sample walks.
// Depends on wbs_pkg; drives the datapath through the command struct.
module wbs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_op,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wbs_pkg::wbs_cmd_type  cmd,
   input  wbs_pkg::wbs_sts_type  sts
);
   import wbs_pkg::*;

   wbs_state_type state_ff;
   wbs_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_free;
   logic          out_load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = cmd.out_empty || cmd.ctr_sum;
   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.cap_req = 1'b1;
               state_in    = (req_op == OP_SAMPLE) ? ST_SMP_INIT : ST_WR_READ;
            end
         end
         ST_WR_READ: begin
            state_in = sts.wr_in_range ? ST_WR_COMMIT : ST_IDLE;
         end
         ST_WR_COMMIT: begin
            cmd.wr_commit = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SMP_INIT: begin
            cmd.smp_init = 1'b1;
            state_in     = sts.total_zero ? ST_EMPTY : ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.hit) begin
               state_in = ST_CTR_MUL;
            end else if (sts.walk_end) begin
               state_in = ST_EMPTY;
            end
         end
         ST_CTR_MUL: begin
            cmd.ctr_mul = 1'b1;
            state_in    = ST_CTR_SUM;
         end
         ST_CTR_SUM: begin
            if (out_free) begin
               cmd.ctr_sum = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               cmd.out_empty = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result beat is loaded only into an empty or draining output register.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a pending beat");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result beat during the clearing pass");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_CTR_SUM || state_ff == ST_EMPTY))
      else $error("result beat not caused by a sample");

endmodule

@@ src/wbs_dp.sv @@
`timescale 1ns / 1ps
// Datapath: weight memory, running total, prefix walk and bin centre arithmetic.
// Depends on wbs_pkg; controlled by wbs_ctrl through command and status structs.
module wbs_dp #(
   parameter int MAX_CELLS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wbs_pkg::wbs_cmd_type                cmd,
   output wbs_pkg::wbs_sts_type                sts,
   input  wbs_pkg::wbs_cfg_type                cfg,
   input  logic [wbs_pkg::ADDR_FIELD_W-1:0]    req_cell_address,
   input  logic [wbs_pkg::WEIGHT_BITS-1:0]     req_weight_value,
   input  logic [wbs_pkg::FRACTION_BITS-1:0]   req_uniform_fraction,
   output logic                                rsp_status,
   output logic [wbs_pkg::IDX_W-1:0]           rsp_col_index,
   output logic [wbs_pkg::IDX_W-1:0]           rsp_row_index,
   output logic signed [wbs_pkg::COORD_W-1:0]  rsp_x_center,
   output logic signed [wbs_pkg::COORD_W-1:0]  rsp_y_center
);
   import wbs_pkg::*;

   localparam int ADDR_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int TOTAL_W    = WEIGHT_BITS + ADDR_W;
   localparam int PROD_W     = TOTAL_W + FRACTION_BITS;
   localparam int CELL_LIMIT = (MAX_CELLS < GRID_CELLS) ? MAX_CELLS : GRID_CELLS;

   logic [WEIGHT_BITS-1:0]   mem [MAX_CELLS];
   logic [WEIGHT_BITS-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [WEIGHT_BITS-1:0]   mem_wdata;

   logic [ADDR_FIELD_W-1:0]  cap_addr_ff;
   logic [WEIGHT_BITS-1:0]   cap_weight_ff;
   logic [FRACTION_BITS-1:0] cap_frac_ff;
   logic [ADDR_W-1:0]        cap_idx;

   logic [ADDR_W-1:0]        clr_ptr_ff, clr_ptr_in;
   logic [TOTAL_W-1:0]       total_ff, total_in;
   logic [CNT_W-1:0]         rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0]         dat_pos_ff, dat_pos_in;
   logic                     dat_vld_ff, dat_vld_in;
   logic [IDX_W-1:0]         col_ff, col_in;
   logic [IDX_W-1:0]         row_ff, row_in;
   logic [TOTAL_W-1:0]       prefix_ff, prefix_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [CP_W-1:0]          xp_ff, yp_ff;

   logic [DIM_W-1:0]         cols_c, rows_c;
   logic [2*DIM_W-1:0]       grid_cells;
   logic [CNT_W-1:0]         grid_n;
   logic [TOTAL_W-1:0]       sum_w;
   logic                     hit_w;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(GRID_MAX)) begin
         r = DIM_W'(GRID_MAX);
      end
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_center(
      input logic signed [COORD_W-1:0] origin,
      input logic [CP_W-2:0]           half
   );
      logic signed [CP_W:0] c;
      logic signed [COORD_W-1:0] r;
      c = signed'({{(CP_W + 1 - COORD_W){origin[COORD_W-1]}}, origin})
          + signed'({2'b00, half});
      if (!c[CP_W] && (c[CP_W-1:COORD_W-1] != '0)) begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         r = c[COORD_W-1:0];
      end
      return r;
   endfunction

   assign cols_c     = clamp_dim(cfg.cols);
   assign rows_c     = clamp_dim(cfg.rows);
   assign grid_cells = cols_c * rows_c;
   assign grid_n     = (grid_cells[CNT_W-1:0] > CNT_W'(CELL_LIMIT)) ?
                       CNT_W'(CELL_LIMIT) : grid_cells[CNT_W-1:0];
   assign cap_idx    = ADDR_W'(cap_addr_ff);

   assign sum_w = prefix_ff + TOTAL_W'(rd_data_ff);
   assign hit_w = dat_vld_ff && ({sum_w, {FRACTION_BITS{1'b0}}} > prod_ff);

   assign sts.clr_done    = (clr_ptr_ff == ADDR_W'(MAX_CELLS - 1));
   assign sts.wr_in_range = (32'(cap_addr_ff) < 32'(MAX_CELLS));
   assign sts.total_zero  = (total_ff == '0);
   assign sts.hit         = hit_w;
   assign sts.walk_end    = dat_vld_ff && !hit_w && (dat_pos_ff == n_ff - 1'b1);

   assign mem_we    = cmd.clr_en || cmd.wr_commit;
   assign mem_waddr = cmd.clr_en ? clr_ptr_ff : cap_idx;
   assign mem_wdata = cmd.clr_en ? '0 : cap_weight_ff;
   assign rd_addr   = cmd.walk ? ADDR_W'(rd_pos_ff) : cap_idx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      clr_ptr_in = clr_ptr_ff;
      total_in   = total_ff;
      rd_pos_in  = rd_pos_ff;
      dat_pos_in = dat_pos_ff;
      dat_vld_in = 1'b0;
      col_in     = col_ff;
      row_in     = row_ff;
      prefix_in  = prefix_ff;
      n_in       = n_ff;
      prod_in    = prod_ff;
      if (cmd.clr_en && !sts.clr_done) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
      end
      if (cmd.wr_commit) begin
         total_in = total_ff - TOTAL_W'(rd_data_ff) + TOTAL_W'(cap_weight_ff);
      end
      if (cmd.smp_init) begin
         rd_pos_in  = '0;
         dat_pos_in = '0;
         col_in     = '0;
         row_in     = '0;
         prefix_in  = '0;
         n_in       = grid_n;
         prod_in    = PROD_W'(cap_frac_ff) * PROD_W'(total_ff);
      end else if (cmd.walk) begin
         if (rd_pos_ff < n_ff) begin
            rd_pos_in  = rd_pos_ff + 1'b1;
            dat_vld_in = 1'b1;
         end
         if (dat_vld_ff && !hit_w) begin
            prefix_in  = sum_w;
            dat_pos_in = dat_pos_ff + 1'b1;
            if (col_ff == IDX_W'(cols_c - 1'b1)) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
         total_ff   <= '0;
         rd_pos_ff  <= '0;
         dat_pos_ff <= '0;
         dat_vld_ff <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
      end else begin
         clr_ptr_ff <= clr_ptr_in;
         total_ff   <= total_in;
         rd_pos_ff  <= rd_pos_in;
         dat_pos_ff <= dat_pos_in;
         dat_vld_ff <= dat_vld_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      prefix_ff <= prefix_in;
      n_ff      <= n_in;
      prod_ff   <= prod_in;
      if (cmd.cap_req) begin
         cap_addr_ff   <= req_cell_address;
         cap_weight_ff <= req_weight_value;
         cap_frac_ff   <= req_uniform_fraction;
      end
      if (cmd.ctr_mul) begin
         xp_ff <= CP_W'({col_ff, 1'b1}) * CP_W'(cfg.x_bin_width);
         yp_ff <= CP_W'({row_ff, 1'b1}) * CP_W'(cfg.y_bin_width);
      end
      if (cmd.ctr_sum) begin
         rsp_status    <= 1'b0;
         rsp_col_index <= col_ff;
         rsp_row_index <= row_ff;
         rsp_x_center  <= sat_center(cfg.x_origin, xp_ff[CP_W-1:1]);
         rsp_y_center  <= sat_center(cfg.y_origin, yp_ff[CP_W-1:1]);
      end else if (cmd.out_empty) begin
         rsp_status    <= 1'b1;
         rsp_col_index <= '0;
         rsp_row_index <= '0;
         rsp_x_center  <= '0;
         rsp_y_center  <= '0;
      end
   end

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      dat_vld_ff |-> ({1'b0, col_ff} < cols_c))
      else $error("column counter ran past the grid width");

   a_prefix_bound: assert property (@(posedge clock) disable iff (reset)
      dat_vld_ff |-> (prefix_ff <= total_ff))
      else $error("prefix sum exceeds the stored total");

endmodule

@@ src/weighted_2d_bin_sampler_top.sv @@
`timescale 1ns / 1ps
// Top level of the weighted two-dimensional bin sampler.
// Depends on wbs_pkg, wbs_regs, wbs_ctrl and wbs_dp.
//
// Weight-write beats (op 0) update one stored cell and the running total
// when the cell address is below MAX_CELLS, with no result beat. A sample
// beat (op 1) draws a cell by walking the stored weights from cell 0, one
// cell per cycle through the single read port of the weight memory, over
// at most n cells with n = min(cols * rows, MAX_CELLS), and returns one
// result beat, which is held back while the previous result still waits on
// rsp_stall. One item is in work at a time; a finished result waits in the
// output register while the next item is accepted. After reset the weight
// memory is cleared, and req_stall stays high while it is; configuration
// writes are taken during that time.
module weighted_2d_bin_sampler_top #(
   parameter int MAX_CELLS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [wbs_pkg::ADDR_FIELD_W-1:0]    req_cell_address,
   input  logic [wbs_pkg::WEIGHT_BITS-1:0]     req_weight_value,
   input  logic [wbs_pkg::FRACTION_BITS-1:0]   req_uniform_fraction,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status,
   output logic [wbs_pkg::IDX_W-1:0]           rsp_col_index,
   output logic [wbs_pkg::IDX_W-1:0]           rsp_row_index,
   output logic signed [wbs_pkg::COORD_W-1:0]  rsp_x_center,
   output logic signed [wbs_pkg::COORD_W-1:0]  rsp_y_center,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [wbs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [wbs_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [wbs_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import wbs_pkg::*;

   wbs_cfg_type cfg;
   wbs_cmd_type cmd;
   wbs_sts_type sts;

   wbs_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   wbs_dp #(
      .MAX_CELLS (MAX_CELLS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .cfg                  (cfg),
      .req_cell_address     (req_cell_address),
      .req_weight_value     (req_weight_value),
      .req_uniform_fraction (req_uniform_fraction),
      .rsp_status           (rsp_status),
      .rsp_col_index        (rsp_col_index),
      .rsp_row_index        (rsp_row_index),
      .rsp_x_center         (rsp_x_center),
      .rsp_y_center         (rsp_y_center)
   );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for weighted_2d_bin_sampler_top: weight writes, draws and register setup.
// Depends on wbs_pkg and the RTL of the sampler; it predicts every result beat on its own.
module tb_top;
   import wbs_pkg::*;

   localparam logic        STATUS_DRAWN = 1'b0;
   localparam logic        STATUS_EMPTY = 1'b1;
   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          SETTLE_GAP   = 32;

   typedef struct packed {
      logic                      status;
      logic [IDX_W-1:0]          col;
      logic [IDX_W-1:0]          row;
      logic signed [COORD_W-1:0] x_mid;
      logic signed [COORD_W-1:0] y_mid;
   } draw_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_op = OP_WRITE;
   logic [ADDR_FIELD_W-1:0]  req_cell_address = '0;
   logic [WEIGHT_BITS-1:0]   req_weight_value = '0;
   logic [FRACTION_BITS-1:0] req_uniform_fraction = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_status;
   logic [IDX_W-1:0]         rsp_col_index;
   logic [IDX_W-1:0]         rsp_row_index;
   logic signed [COORD_W-1:0] rsp_x_center;
   logic signed [COORD_W-1:0] rsp_y_center;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    paddr = '0;
   logic [CSR_DATA_W-1:0]    pwdata = '0;
   logic [CSR_DATA_W-1:0]    prdata;
   logic                     pready;

   logic [WEIGHT_BITS-1:0] cell_weight [GRID_CELLS] = '{default: '0};
   longint unsigned        weight_sum = 0;
   logic [DIM_W-1:0]       grid_cols = 7'd64;
   logic [DIM_W-1:0]       grid_rows = 7'd64;
   logic [COORD_W-1:0]     x_org = '0;
   logic [COORD_W-1:0]     y_org = '0;
   logic [BW_W-1:0]        x_bw = 31'd65536;
   logic [BW_W-1:0]        y_bw = 31'd65536;

   draw_type draws_expected[$];

   int unsigned errors = 0;
   int unsigned cycle_count = 0;
   int unsigned writes_sent = 0;
   int unsigned draws_sent = 0;
   int unsigned empty_draws = 0;
   int unsigned grid_settings = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_requests = 0;
   int          holds_served = 0;
   int          hold_left = 0;

   weighted_2d_bin_sampler_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_cell_address(req_cell_address), .req_weight_value(req_weight_value),
      .req_uniform_fraction(req_uniform_fraction),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_col_index(rsp_col_index), .rsp_row_index(rsp_row_index),
      .rsp_x_center(rsp_x_center), .rsp_y_center(rsp_y_center),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("weighted_2d_bin_sampler_top: mismatch");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      if (errors <= 40)
         $display("ERROR %0t ns: %s got %0h expected %0h", $time, what, got, want);
   endtask

   function automatic int grid_dim(input logic [DIM_W-1:0] dim);
      if (dim == 0) return 1;
      if (dim > GRID_MAX) return GRID_MAX;
      return int'(dim);
   endfunction

   function automatic logic [COORD_W-1:0] bin_mid(input logic [COORD_W-1:0] origin,
                                                  input int idx,
                                                  input logic [BW_W-1:0] width);
      longint mid;
      mid = longint'($signed(origin)) + ((2 * longint'(idx) + 1) * longint'(width)) / 2;
      if (mid > 64'sd2147483647) mid = 64'sd2147483647;
      if (mid < -64'sd2147483648) mid = -64'sd2147483648;
      return mid[COORD_W-1:0];
   endfunction

   // The wheel stops at the first cell whose prefix sum, scaled by 2^16,
   // exceeds the fraction times the total of all stored weights.
   function automatic draw_type predict_draw(input logic [FRACTION_BITS-1:0] frac);
      draw_type        res;
      int              cols;
      int              rows;
      int              cells;
      int              pos;
      longint unsigned aim;
      longint unsigned run;
      res = '0;
      res.status = STATUS_EMPTY;
      if (weight_sum == 0) return res;
      cols = grid_dim(grid_cols);
      rows = grid_dim(grid_rows);
      cells = cols * rows;
      if (cells > GRID_CELLS) cells = GRID_CELLS;
      aim = longint'(frac) * weight_sum;
      run = 0;
      for (pos = 0; pos < cells; pos++) begin
         run += 64'(cell_weight[pos]);
         if ((run << FRACTION_BITS) > aim) begin
            res.status = STATUS_DRAWN;
            res.col = IDX_W'(pos % cols);
            res.row = IDX_W'(pos / cols);
            res.x_mid = bin_mid(x_org, pos % cols, x_bw);
            res.y_mid = bin_mid(y_org, pos / cols, y_bw);
            return res;
         end
      end
      return res;
   endfunction

   function automatic logic [31:0] reg_mask(input logic [2:0] idx);
      case (idx)
         REG_COLS, REG_ROWS: return 32'h0000_007F;
         REG_X_BW, REG_Y_BW: return 32'h7FFF_FFFF;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   always @(posedge clock) begin
      draw_type want;
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_requests != holds_served) begin
         rsp_stall <= 1'b1;
         hold_left = HOLD_CYCLES;
         holds_served++;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (draws_expected.size() == 0) begin
            report_mismatch("result beat with no draw pending", 64'(rsp_status), 64'd0);
         end else begin
            want = draws_expected.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_col_index !== want.col)
               report_mismatch("col_index", 64'(rsp_col_index), 64'(want.col));
            if (rsp_row_index !== want.row)
               report_mismatch("row_index", 64'(rsp_row_index), 64'(want.row));
            if (rsp_x_center !== want.x_mid)
               report_mismatch("x_center", 64'(rsp_x_center), 64'(want.x_mid));
            if (rsp_y_center !== want.y_mid)
               report_mismatch("y_center", 64'(rsp_y_center), 64'(want.y_mid));
         end
      end
   end

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 19;
            recv_idle_pct = 71;
         end
         1: begin
            send_idle_pct = 71;
            recv_idle_pct = 19;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic send_beat(input logic op, input logic [ADDR_FIELD_W-1:0] addr,
                            input logic [WEIGHT_BITS-1:0] weight,
                            input logic [FRACTION_BITS-1:0] frac);
      draw_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_cell_address <= addr;
      req_weight_value <= weight;
      req_uniform_fraction <= frac;
      do @(posedge clock); while (req_stall);
      if (op == OP_WRITE) begin
         weight_sum = weight_sum - 64'(cell_weight[addr]) + 64'(weight);
         cell_weight[addr] = weight;
         writes_sent++;
      end else begin
         want = predict_draw(frac);
         if (want.status == STATUS_EMPTY) empty_draws++;
         draws_expected.push_back(want);
         draws_sent++;
      end
   endtask

   task automatic put_weight(input logic [ADDR_FIELD_W-1:0] addr,
                             input logic [WEIGHT_BITS-1:0] weight);
      send_beat(OP_WRITE, addr, weight, FRACTION_BITS'($urandom));
   endtask

   task automatic draw(input logic [FRACTION_BITS-1:0] frac);
      send_beat(OP_SAMPLE, ADDR_FIELD_W'($urandom), WEIGHT_BITS'($urandom), frac);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (draws_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] seen;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_COLS:  grid_cols = value[DIM_W-1:0];
         REG_ROWS:  grid_rows = value[DIM_W-1:0];
         REG_X_ORG: x_org = value;
         REG_Y_ORG: y_org = value;
         REG_X_BW:  x_bw = value[BW_W-1:0];
         REG_Y_BW:  y_bw = value[BW_W-1:0];
         default: ;
      endcase
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      seen = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if ((seen & reg_mask(idx)) !== (value & reg_mask(idx)))
         report_mismatch("register readback", 64'(seen & reg_mask(idx)),
                         64'(value & reg_mask(idx)));
   endtask

   task automatic program_grid(input logic [31:0] cols, input logic [31:0] rows,
                               input logic [31:0] xo, input logic [31:0] yo,
                               input logic [31:0] xw, input logic [31:0] yw);
      settle();
      write_reg(REG_COLS, cols);
      write_reg(REG_ROWS, rows);
      write_reg(REG_X_ORG, xo);
      write_reg(REG_Y_ORG, yo);
      write_reg(REG_X_BW, xw);
      write_reg(REG_Y_BW, yw);
      grid_settings++;
   endtask

   task automatic test_empty_table();
      draw(16'h0000);
      draw(16'hFFFF);
      settle();
   endtask

   // Zero-weight cells are skipped, and weight beyond the grid can swallow a draw.
   task automatic test_selection_rules();
      program_grid(4, 3, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000);
      put_weight(12'd0, 16'd0);
      put_weight(12'd1, 16'hFFFF);
      put_weight(12'd5, 16'd1);
      put_weight(12'd11, 16'd300);
      put_weight(12'd4095, 16'hFFFF);
      draw(16'h0000);
      draw(16'h7FFF);
      draw(16'hFFFF);
      put_weight(12'd4095, 16'd0);
      draw(16'hFFFF);
      put_weight(12'd1, 16'd0);
      put_weight(12'd5, 16'd0);
      put_weight(12'd11, 16'd0);
      draw(16'h8000);
      settle();
   endtask

   // Out-of-range grid sizes are clamped and bin centers saturate at the top.
   task automatic test_bin_centers();
      program_grid(0, 100, 32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      put_weight(12'd63, 16'd1);
      draw(16'h1234);
      put_weight(12'd0, 16'd7);
      put_weight(12'd64, 16'd9);
      draw(16'h0000);
      draw(16'hFFFF);
      program_grid(127, 0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
      draw(16'h8000);
      draw(16'h3000);
      settle();
   endtask

   task automatic test_random_round(input int mode, input int count);
      logic [DIM_W-1:0]        cols;
      logic [DIM_W-1:0]        rows;
      logic [31:0]             xw;
      logic [31:0]             yw;
      logic [ADDR_FIELD_W-1:0] addr;
      logic [WEIGHT_BITS-1:0]  weight;
      int                      cells;
      int                      pick;
      set_idling(mode);
      case ($urandom_range(7))
         0: begin
            cols = 7'd64;
            rows = 7'd64;
         end
         1: begin
            cols = DIM_W'($urandom_range(127));
            rows = DIM_W'($urandom_range(127));
         end
         default: begin
            cols = DIM_W'($urandom_range(1, 8));
            rows = DIM_W'($urandom_range(1, 8));
         end
      endcase
      xw = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0004_0000);
      yw = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0004_0000);
      program_grid(32'(cols), 32'(rows), $urandom, $urandom, xw, yw);
      cells = grid_dim(cols) * grid_dim(rows);
      repeat (count) begin
         if ($urandom_range(99) < 55) begin
            if ($urandom_range(4) == 0) addr = ADDR_FIELD_W'($urandom_range(4095));
            else addr = ADDR_FIELD_W'($urandom_range(cells - 1));
            pick = $urandom_range(9);
            if (pick < 2) weight = '0;
            else if (pick == 2) weight = '1;
            else weight = WEIGHT_BITS'($urandom);
            put_weight(addr, weight);
         end else begin
            draw(FRACTION_BITS'($urandom));
         end
      end
      settle();
   endtask

   // The receiver holds off for a long stretch while draws keep coming, so
   // the block fills up and stalls its input.
   task automatic test_backpressure();
      set_idling(2);
      program_grid(3, 2, $urandom, $urandom, $urandom_range(32'h0002_0000),
                   $urandom_range(32'h0002_0000));
      put_weight(12'd1, WEIGHT_BITS'($urandom));
      put_weight(12'd4, WEIGHT_BITS'($urandom));
      hold_requests++;
      repeat (10) draw(FRACTION_BITS'($urandom));
      settle();
   endtask

   initial begin
      set_idling(0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_selection_rules();
      test_bin_centers();
      for (int round = 0; round < 6; round++) test_random_round(round / 2, 18);
      test_backpressure();
      repeat (64) @(posedge clock);
      $display("Covered %0d weight writes and %0d draws (%0d with nothing to pick)",
               writes_sent, draws_sent, empty_draws);
      $display("over %0d grid settings, with idling on both sides and a long output stall.",
               grid_settings);
      if (errors == 0) begin
         $display("weighted_2d_bin_sampler_top: match");
      end else begin
         $display("weighted_2d_bin_sampler_top: mismatch");
      end
      $finish;
   end

endmodule
